@@ src/lgs_pkg.sv @@
// Package for the toroidal life grid block: grid geometry, field widths,
// opcodes and the per-cell next-generation rule. No dependencies.
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int ROWS = 64;
    localparam int COLS = 64;

    localparam int OPCODE_W = 2;
    localparam int ADDR_W   = 6;

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    typedef logic [COLS-1:0] row_t;

    // A cell lives in the next generation with exactly three live neighbors,
    // or with two if it is alive now.
    function automatic logic life_rule(input logic alive, input logic [3:0] nbr_count);
        life_rule = (nbr_count == 4'd3) || (alive && (nbr_count == 4'd2));
    endfunction

endpackage

@@ src/life_grid_generation_step_core.sv @@
// Top level of the toroidal life grid: row-wide ping-pong grid memory,
// cell read/write sequencer and the row-at-a-time generation step.
// Depends on lgs_pkg.
`timescale 1ns / 1ps

// The grid lives in one synchronous memory with one row of COLS cells per
// word and two banks, the current generation and the next. Reads and writes
// of a cell read the row at acceptance; the RMW state then picks or merges
// the bit and writes the row back, and the OUT state moves the result to the
// output register once that register is free. An unused opcode goes straight
// to the OUT state with a dead cell as its result. In a step the single read
// port fetches one row per cycle, in the order last row, rows 0 to ROWS-1,
// then row 0 again, so a sliding window of three rows yields one finished
// row of the next generation per cycle, written into the other bank; at the
// end the banks swap roles. One item is in flight at a time, but a new
// transaction is taken while a finished result still waits in the output
// register. After reset the grid reads as all dead at once: each row of the
// first bank carries a valid flag that reset clears, and a row whose flag is
// low reads as zeros until it is first written.
module life_grid_generation_step_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lgs_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [lgs_pkg::ADDR_W-1:0]    s_row,
    input  logic [lgs_pkg::ADDR_W-1:0]    s_col,
    input  logic                          s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_cell_alive
);
    import lgs_pkg::*;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RMW  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int MEM_AW    = ROW_W + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int CNT_W     = $clog2(ROWS + 3);
    // A step reads ROWS rows plus one wrapped row at each end.
    localparam logic [CNT_W-1:0] STEP_READS = CNT_W'(ROWS + 2);
    localparam logic [CNT_W-1:0] LAST_RECV  = CNT_W'(ROWS + 1);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);

    // Grid memory: bank bit on top, row below.
    row_t mem_ram [0:MEM_DEPTH-1];

    logic [1:0]        state_reg, state_next;
    logic              cur_reg, cur_next;
    logic [ROWS-1:0]   valid_reg, valid_next;
    logic              pend_reg, pend_next;
    logic              rd_ok_reg, rd_ok_next;
    row_t              rd_data_reg;
    logic [CNT_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]  rcv_cnt_reg, rcv_cnt_next;
    logic [ROW_W-1:0]  rd_row_reg, rd_row_next;
    logic [ROW_W-1:0]  wr_row_reg, wr_row_next;
    row_t              up_reg, up_next;
    row_t              mid_reg, mid_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              op_wr_reg, op_wr_next;
    logic              val_reg, val_next;
    logic              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_alive_reg, m_alive_next;

    logic              mem_re;
    logic [MEM_AW-1:0] mem_raddr;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    row_t              mem_wdata;

    row_t              row_data;
    row_t              merged_row;
    row_t              gen_row;
    logic              in_range;
    logic              accept;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_cell_alive = m_alive_reg;

    assign in_range = (int'(s_row) < ROWS) && (int'(s_col) < COLS);

    // Rows of the first bank never written since reset read as dead.
    assign row_data = rd_ok_reg ? rd_data_reg : '0;

    always_comb begin
        merged_row          = row_data;
        merged_row[col_reg] = val_reg;
    end

    // Next generation of the middle row of the window, with wrapped columns.
    always_comb begin
        logic [3:0] nbr;
        int         cm;
        int         cp;
        for (int c = 0; c < COLS; c++) begin
            cm  = (c == 0) ? COLS - 1 : c - 1;
            cp  = (c == COLS - 1) ? 0 : c + 1;
            nbr = 4'(up_reg[cm]) + 4'(up_reg[c]) + 4'(up_reg[cp])
                + 4'(mid_reg[cm]) + 4'(mid_reg[cp])
                + 4'(row_data[cm]) + 4'(row_data[c]) + 4'(row_data[cp]);
            gen_row[c] = life_rule(mid_reg[c], nbr);
        end
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        valid_next   = valid_reg;
        pend_next    = 1'b0;
        rd_ok_next   = rd_ok_reg;
        iss_cnt_next = iss_cnt_reg;
        rcv_cnt_next = rcv_cnt_reg;
        rd_row_next  = rd_row_reg;
        wr_row_next  = wr_row_reg;
        up_next      = up_reg;
        mid_next     = mid_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        op_wr_next   = op_wr_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_alive_next = m_alive_reg;
        mem_re       = 1'b0;
        mem_raddr    = {cur_reg, rd_row_reg};
        mem_we       = 1'b0;
        mem_waddr    = {cur_reg, row_reg};
        mem_wdata    = merged_row;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    row_next   = ROW_W'(s_row);
                    col_next   = COL_W'(s_col);
                    op_wr_next = (s_opcode == OP_WRITE);
                    val_next   = s_value;
                    if (s_opcode == OP_STEP) begin
                        iss_cnt_next = '0;
                        rcv_cnt_next = '0;
                        rd_row_next  = LAST_ROW;
                        wr_row_next  = '0;
                        state_next   = ST_STEP;
                    end else if ((s_opcode == OP_WRITE || s_opcode == OP_READ) && in_range) begin
                        mem_re     = 1'b1;
                        mem_raddr  = {cur_reg, ROW_W'(s_row)};
                        rd_ok_next = cur_reg || valid_reg[ROW_W'(s_row)];
                        pend_next  = 1'b1;
                        state_next = ST_RMW;
                    end else begin
                        res_next   = 1'b0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RMW: begin
                if (op_wr_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = {cur_reg, row_reg};
                    mem_wdata = merged_row;
                    if (!cur_reg) begin
                        valid_next[row_reg] = 1'b1;
                    end
                    res_next = val_reg;
                end else begin
                    res_next = row_data[col_reg];
                end
                state_next = ST_OUT;
            end
            ST_STEP: begin
                if (iss_cnt_reg < STEP_READS) begin
                    mem_re       = 1'b1;
                    mem_raddr    = {cur_reg, rd_row_reg};
                    rd_ok_next   = cur_reg || valid_reg[rd_row_reg];
                    pend_next    = 1'b1;
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                    rd_row_next  = (rd_row_reg == LAST_ROW) ? '0 : rd_row_reg + 1'b1;
                end
                if (pend_reg) begin
                    // Window full: up, mid and the arriving row give one new row.
                    if (rcv_cnt_reg >= CNT_W'(2)) begin
                        mem_we      = 1'b1;
                        mem_waddr   = {~cur_reg, wr_row_reg};
                        mem_wdata   = gen_row;
                        wr_row_next = wr_row_reg + 1'b1;
                        if (cur_reg) begin
                            valid_next[wr_row_reg] = 1'b1;
                        end
                    end
                    up_next      = mid_reg;
                    mid_next     = row_data;
                    rcv_cnt_next = rcv_cnt_reg + 1'b1;
                    if (rcv_cnt_reg == LAST_RECV) begin
                        cur_next   = ~cur_reg;
                        res_next   = 1'b0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_alive_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= 1'b0;
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ok_reg   <= rd_ok_next;
        iss_cnt_reg <= iss_cnt_next;
        rcv_cnt_reg <= rcv_cnt_next;
        rd_row_reg  <= rd_row_next;
        wr_row_reg  <= wr_row_next;
        up_reg      <= up_next;
        mid_reg     <= mid_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        op_wr_reg   <= op_wr_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
        m_alive_reg <= m_alive_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem_ram[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_step_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (iss_cnt_reg <= STEP_READS))
        else $error("step issued more row reads than the window needs");

    a_step_write_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && mem_we) |-> (mem_waddr[MEM_AW-1] != cur_reg))
        else $error("step wrote into the bank it is reading");

    a_step_bank_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && state_next == ST_OUT) |=> (cur_reg != $past(cur_reg)))
        else $error("banks did not swap at the end of a step");

    a_pend_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_STEP || state_reg == ST_RMW))
        else $error("read data arrived outside a memory sequence");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && state_reg != ST_OUT) |=> !m_valid_reg)
        else $error("result register reloaded without a finished transaction");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the toroidal life grid core: cell writes, cell reads,
// generation steps and the unused opcode, checked against a behavioral grid model.
// Depends on lgs_pkg and life_grid_generation_step_core.
`timescale 1ns / 1ps

module tb;

    import lgs_pkg::*;

    // The opcode value that the block does not define. It must leave the grid alone
    // and answer with a dead cell.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int DIRECTED_ITEMS_MAX = 25;
    localparam int RANDOM_ITEMS       = 140 - DIRECTED_ITEMS_MAX;
    localparam int MAX_IDLE           = 11;
    // The receiver stops taking results for this many cycles once, so that the
    // output register and the one item in flight fill up and s_ready drops.
    localparam int LONG_HOLD_CYCLES   = 400;
    localparam int LONG_HOLD_AT       = 25;
    // The drain at the end covers one step with margin.
    localparam int DRAIN_CYCLES       = ROWS + 20;
    // Slowest legal quiet stretch: the long hold, plus a full step, plus the
    // longest gap on each side. The limit is several times that.
    localparam int WATCHDOG_LIMIT     = 4 * (LONG_HOLD_CYCLES + ROWS + 4 + 2 * MAX_IDLE);

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ADDR_W-1:0]   row;
        logic [ADDR_W-1:0]   col;
        logic                value;
    } grid_item_t;

    // One expected result, kept with the transaction that caused it so that a
    // mismatch report can name the operation and the address.
    typedef struct packed {
        grid_item_t src;
        logic       alive;
    } alive_want_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode = '0;
    logic [ADDR_W-1:0]   s_row    = '0;
    logic [ADDR_W-1:0]   s_col    = '0;
    logic                s_value  = 1'b0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic                m_cell_alive;

    life_grid_generation_step_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_alive (m_cell_alive)
    );

    // Transactions waiting to be offered, in order, and the results still owed.
    grid_item_t  pending_q[$];
    alive_want_t alive_want_q[$];

    // Our own copy of the grid. It starts all dead, which is the state after reset.
    bit life_grid [ROWS][COLS];

    int unsigned n_items_total = 0;
    int unsigned n_accepted    = 0;
    int unsigned n_results     = 0;
    int unsigned n_writes      = 0;
    int unsigned n_reads       = 0;
    int unsigned n_steps       = 0;
    int unsigned n_unused      = 0;
    int unsigned n_errors      = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic int unsigned draw_idle(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Replace the whole grid with its next generation. Every neighbor index wraps
    // at the edges, so the grid behaves as a torus.
    function automatic void advance_generation();
        bit nxt [ROWS][COLS];
        int nbrs;
        int rr;
        int cc;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            rr = (r + dr + ROWS) % ROWS;
                            cc = (c + dc + COLS) % COLS;
                            nbrs += life_grid[rr][cc];
                        end
                    end
                end
                if (life_grid[r][c])
                    nxt[r][c] = (nbrs == 2) || (nbrs == 3);
                else
                    nxt[r][c] = (nbrs == 3);
            end
        end
        life_grid = nxt;
    endfunction

    // Update the grid model for one accepted transaction and queue the result it owes.
    function automatic void apply_transaction(input grid_item_t it);
        alive_want_t want;
        bit in_grid;
        want.src   = it;
        want.alive = 1'b0;
        in_grid    = (int'(it.row) < ROWS) && (int'(it.col) < COLS);
        case (it.opcode)
            OP_WRITE: begin
                n_writes++;
                if (in_grid) begin
                    life_grid[it.row][it.col] = it.value;
                    want.alive = it.value;
                end
            end
            OP_READ: begin
                n_reads++;
                if (in_grid)
                    want.alive = life_grid[it.row][it.col];
            end
            OP_STEP: begin
                n_steps++;
                advance_generation();
            end
            default: begin
                n_unused++;
            end
        endcase
        alive_want_q.push_back(want);
    endfunction

    function automatic void push_item(input logic [OPCODE_W-1:0] op, input int row,
                                      input int col, input bit value);
        grid_item_t it;
        it.opcode = op;
        it.row    = ADDR_W'(row);
        it.col    = ADDR_W'(col);
        it.value  = value;
        pending_q.push_back(it);
        n_items_total++;
    endfunction

    // Sender: offers one transaction at a time from pending_q, with a random gap
    // before each one. Once valid is up it holds with a stable payload until the
    // block takes it. The model is updated at the edge of acceptance.
    grid_item_t  tx_item;
    int unsigned tx_wait  = 0;
    bit          tx_burst = 1'b0;

    always @(posedge aclk) begin : cell_driver
        grid_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = draw_idle(tx_burst);
        end else begin
            if (s_valid && s_ready) begin
                apply_transaction(tx_item);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    nxt      = pending_q.pop_front();
                    tx_item  = nxt;
                    s_valid  <= 1'b1;
                    s_opcode <= nxt.opcode;
                    s_row    <= nxt.row;
                    s_col    <= nxt.col;
                    s_value  <= nxt.value;
                    // Flip between gappy and back-to-back stretches now and then.
                    if ($urandom_range(0, 15) == 0)
                        tx_burst = !tx_burst;
                    tx_wait = draw_idle(tx_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest owed one, then draws a
    // stall before it takes the next. Once in the run it holds off for a long
    // stretch while the sender keeps offering, so that the block backs up.
    int unsigned rx_wait   = 0;
    bit          rx_burst  = 1'b0;
    bit          hold_done = 1'b0;

    always @(posedge aclk) begin : result_monitor
        alive_want_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = draw_idle(rx_burst);
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (alive_want_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed, cell_alive=%0b",
                                              m_cell_alive));
                end else begin
                    want = alive_want_q.pop_front();
                    if (m_cell_alive !== want.alive)
                        report_mismatch($sformatf(
                            "op=%0d row=%0d col=%0d value=%0b: cell_alive=%0b, want %0b",
                            want.src.opcode, want.src.row, want.src.col, want.src.value,
                            m_cell_alive, want.alive));
                end
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
                rx_wait = draw_idle(rx_burst);
                if (n_results == LONG_HOLD_AT && !hold_done) begin
                    rx_wait   = LONG_HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (rx_wait != 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles with no transaction on either side means
    // the block has hung.
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d quiet cycles, %0d of %0d transactions taken",
                         quiet_cycles, n_accepted, n_items_total);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic int live_count();
        int n;
        n = 0;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                n += life_grid[r][c];
        return n;
    endfunction

    initial begin : stimulus
        int win_r;
        int win_c;
        int pick;
        int rows_m1;
        int cols_m1;

        rows_m1 = ROWS - 1;
        cols_m1 = COLS - 1;

        // Directed part. Reads right after reset must see the cleared grid.
        push_item(OP_READ, 0, 0, 1'b1);
        push_item(OP_READ, rows_m1, cols_m1, 1'b0);
        // The four corners touch across both wraps and form a 2x2 block, a still life.
        push_item(OP_WRITE, 0, 0, 1'b1);
        push_item(OP_WRITE, rows_m1, cols_m1, 1'b1);
        push_item(OP_WRITE, 0, cols_m1, 1'b1);
        push_item(OP_WRITE, rows_m1, 0, 1'b1);
        // The unused opcode with every field bit set must not disturb the grid.
        push_item(OP_UNUSED, 63, 63, 1'b1);
        // A step ignores its address and value fields, so set them all.
        push_item(OP_STEP, 63, 63, 1'b1);
        push_item(OP_READ, 0, 0, 1'b0);
        push_item(OP_READ, rows_m1, cols_m1, 1'b1);
        // Kill one corner: it has the other three as neighbors, so it comes back.
        push_item(OP_WRITE, 0, 0, 1'b0);
        push_item(OP_STEP, 0, 0, 1'b0);
        push_item(OP_READ, 0, 0, 1'b0);
        // Writing a dead value over a dead cell.
        push_item(OP_WRITE, 32, 32, 1'b0);
        // A horizontal blinker that straddles the column wrap.
        push_item(OP_WRITE, 31, cols_m1, 1'b1);
        push_item(OP_WRITE, 31, 0, 1'b1);
        push_item(OP_WRITE, 31, 1, 1'b1);
        push_item(OP_READ, 31, 0, 1'b0);
        push_item(OP_STEP, 21, 42, 1'b0);
        push_item(OP_READ, 30, 0, 1'b1);
        push_item(OP_READ, 32, 0, 1'b0);
        push_item(OP_READ, 31, cols_m1, 1'b0);
        push_item(OP_UNUSED, 0, 0, 1'b0);

        // Random part. Most traffic seeds and probes a small window so that the
        // steps evolve real patterns; the window moves now and then and often lands
        // across an edge. The rest is steps, scattered access and the unused opcode.
        win_r = $urandom_range(0, rows_m1);
        win_c = $urandom_range(0, cols_m1);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                push_item(OP_WRITE, (win_r + $urandom_range(0, 5)) % ROWS,
                          (win_c + $urandom_range(0, 5)) % COLS, $urandom_range(0, 99) < 55);
            end else if (pick < 68) begin
                push_item(OP_READ, (win_r + $urandom_range(0, 5)) % ROWS,
                          (win_c + $urandom_range(0, 5)) % COLS, $urandom_range(0, 1));
            end else if (pick < 80) begin
                push_item(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0) begin
                    win_r = ($urandom_range(0, 1) != 0) ? rows_m1 - 2 : $urandom_range(0, rows_m1);
                    win_c = ($urandom_range(0, 1) != 0) ? cols_m1 - 2 : $urandom_range(0, cols_m1);
                end
            end else if (pick < 92) begin
                push_item(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ,
                          $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
            end else begin
                push_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1));
            end
        end

        // Single reset at the start of the run.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted != n_items_total || alive_want_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d writes, %0d reads, %0d generation steps, %0d unused opcodes",
                 n_writes, n_reads, n_steps, n_unused);
        $display("%0d results checked, %0d live cells at the end, %0d mismatches",
                 n_results, live_count(), n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/lgs_pkg.sv
src/life_grid_generation_step_core.sv
verif/tb.sv
